@@ design/rmts_pkg.sv @@
// Package of the rate monotonic tick scheduler: item modes, task entry layout, control types.
package rmts_pkg;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	localparam int PERIOD_W  = 16;
	localparam int BUDGET_W  = 16;
	localparam int TIME_W    = 32;
	localparam int SLOT_W    = 3;
	localparam int RUNNING_W = 4;

	// One task entry as held in the task table.
	typedef struct packed {
		logic [PERIOD_W-1:0] period;
		logic [BUDGET_W-1:0] budget;
		logic [TIME_W-1:0]   next_rel;
		logic [BUDGET_W-1:0] remaining;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_en;
		logic tick_start;
		logic scan_en;
		logic commit;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_last;
		logic out_free;
	} sts_t;

endpackage

@@ design/rmts_cmd_if.sv @@
// Input item channel of the scheduler: task loads and time ticks.
interface rmts_cmd_if;
	logic                        valid;
	logic                        ready;
	logic                        mode;
	logic [rmts_pkg::SLOT_W-1:0]   task_slot;
	logic [rmts_pkg::PERIOD_W-1:0] task_period;
	logic [rmts_pkg::BUDGET_W-1:0] task_budget;
	logic [rmts_pkg::TIME_W-1:0]   first_release;

	modport source (output valid, mode, task_slot, task_period, task_budget, first_release,
		input ready);
	modport sink (input valid, mode, task_slot, task_period, task_budget, first_release,
		output ready);
endinterface

@@ design/rmts_sched_if.sv @@
// Result item channel of the scheduler: one scheduling decision per tick.
interface rmts_sched_if;
	logic                           valid;
	logic                           ready;
	logic [rmts_pkg::TIME_W-1:0]    tick_time;
	logic [rmts_pkg::RUNNING_W-1:0] running_task;

	modport source (output valid, tick_time, running_task, input ready);
	modport sink (input valid, tick_time, running_task, output ready);
endinterface

@@ design/rate_monotonic_tick_scheduler_top.sv @@
// Top level of the rate monotonic tick scheduler: controller plus datapath.
//
// Usage:
//   cmd carries input items. A load item (mode 0) writes one task's period,
//   budget and first release and clears its remaining work; loads to a slot
//   at or above TASK_COUNT are dropped. A tick item (mode 1) releases due
//   tasks, runs the ready task with the shortest period (lowest index on a
//   tie) and advances time.
//   sched carries one result item per tick: the tick's time and the task
//   number plus one that ran, 0 when idle. Loads produce no result.
// Sequence:
//   A load is written as it is accepted. A tick starts the read of the first
//   entry, then scans every table entry through the single read port and the
//   single write port of the task memory, then commits the decision.
//   The result appears in the cycle after the commit.
// Reset and stall:
//   arst_n clears time, the task table valid bits and all control; every task
//   then reads as disabled. A stalled sched holds the result in its register;
//   loads and the next tick's scan still proceed, then its commit waits and no item is accepted meanwhile.
module rate_monotonic_tick_scheduler_top #(
	parameter int TASK_COUNT = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	rmts_cmd_if.sink     cmd,
	rmts_sched_if.source sched
);

	rmts_pkg::ctl_t ctl;
	rmts_pkg::sts_t sts;

	// sequence each item
	rmts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_mode  (cmd.mode),
		.cmd_ready (cmd.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	// hold the task table, scan it and register the decision
	rmts_dp #(
		.TASK_COUNT (TASK_COUNT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.task_slot     (cmd.task_slot),
		.task_period   (cmd.task_period),
		.task_budget   (cmd.task_budget),
		.first_release (cmd.first_release),
		.out_valid     (sched.valid),
		.out_ready     (sched.ready),
		.tick_time     (sched.tick_time),
		.running_task  (sched.running_task)
	);

endmodule

@@ design/rmts_ctrl.sv @@
// Controller of the scheduler: sequences load, table scan and commit of each tick.
module rmts_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	input  logic            cmd_mode,
	output logic            cmd_ready,
	input  rmts_pkg::sts_t  sts,
	output rmts_pkg::ctl_t  ctl
);

	rmts_pkg::state_t state_q;
	rmts_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rmts_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		ctl       = '0;
		unique case (state_q)
			rmts_pkg::ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					if (cmd_mode == rmts_pkg::MODE_TICK) begin
						ctl.tick_start = 1'b1;
						state_d        = rmts_pkg::ST_SCAN;
					end else begin
						ctl.load_en = 1'b1;
					end
				end
			end
			rmts_pkg::ST_SCAN: begin
				ctl.scan_en = 1'b1;
				if (sts.scan_last) begin
					state_d = rmts_pkg::ST_DONE;
				end
			end
			rmts_pkg::ST_DONE: begin
				// hold until the result register can take the decision
				if (sts.out_free) begin
					ctl.commit = 1'b1;
					state_d    = rmts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rmts_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ design/rmts_dp.sv @@
// Datapath of the scheduler: task table memory, release update, priority pick, result register.
module rmts_dp #(
	parameter int TASK_COUNT = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rmts_pkg::ctl_t                 ctl,
	output rmts_pkg::sts_t                 sts,
	input  logic [rmts_pkg::SLOT_W-1:0]    task_slot,
	input  logic [rmts_pkg::PERIOD_W-1:0]  task_period,
	input  logic [rmts_pkg::BUDGET_W-1:0]  task_budget,
	input  logic [rmts_pkg::TIME_W-1:0]    first_release,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [rmts_pkg::TIME_W-1:0]    tick_time,
	output logic [rmts_pkg::RUNNING_W-1:0] running_task
);

	localparam int IDX_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_COUNT - 1);

	rmts_pkg::entry_t mem [TASK_COUNT];
	logic [TASK_COUNT-1:0] entry_vld_q;

	rmts_pkg::entry_t rdata_q;
	logic             rd_vld_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic [IDX_W-1:0] proc_idx_q;
	logic [IDX_W-1:0] rd_addr;
	logic             rd_en;

	logic             best_vld_q;
	logic [IDX_W-1:0] best_idx_q;
	rmts_pkg::entry_t best_q;

	logic [rmts_pkg::TIME_W-1:0]    time_q;
	logic                           out_vld_q;
	logic [rmts_pkg::TIME_W-1:0]    tick_time_q;
	logic [rmts_pkg::RUNNING_W-1:0] running_q;

	logic             slot_ok;
	logic [IDX_W-1:0] slot_idx;
	rmts_pkg::entry_t cur;
	rmts_pkg::entry_t upd;
	rmts_pkg::entry_t load_entry;
	rmts_pkg::entry_t commit_entry;
	logic             release_hit;
	logic             take;

	assign slot_ok  = int'(task_slot) < TASK_COUNT;
	assign slot_idx = IDX_W'(task_slot);

	assign load_entry = '{period: task_period, budget: task_budget,
		next_rel: first_release, remaining: '0};

	// entry never loaded reads as the reset entry
	assign cur = rd_vld_q ? rdata_q : '0;

	always_comb begin
		release_hit = (cur.period != '0) && (cur.next_rel == time_q);
		upd         = cur;
		if (release_hit) begin
			upd.remaining = cur.budget;
			upd.next_rel  = cur.next_rel + rmts_pkg::TIME_W'(cur.period);
		end
		// strict less keeps the lowest index on equal periods
		take = (upd.remaining != '0) && (!best_vld_q || (cur.period < best_q.period));
	end

	always_comb begin
		commit_entry           = best_q;
		commit_entry.remaining = best_q.remaining - rmts_pkg::BUDGET_W'(1);
	end

	assign rd_addr = ctl.tick_start ? '0 : rd_idx_q;
	assign rd_en   = ctl.tick_start || (ctl.scan_en && (proc_idx_q != LAST_IDX));

	assign sts.scan_last = (proc_idx_q == LAST_IDX);
	assign sts.out_free  = !out_vld_q || out_ready;

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (ctl.load_en && slot_ok) begin
			mem[slot_idx] <= load_entry;
		end else if (ctl.scan_en) begin
			mem[proc_idx_q] <= upd;
		end else if (ctl.commit && best_vld_q) begin
			mem[best_idx_q] <= commit_entry;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_vld_q <= '0;
			rd_vld_q    <= 1'b0;
		end else begin
			if (ctl.load_en && slot_ok) begin
				entry_vld_q[slot_idx] <= 1'b1;
			end else if (ctl.scan_en) begin
				entry_vld_q[proc_idx_q] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= entry_vld_q[rd_addr];
			end
		end
	end

	// scan indexes and running best candidate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q   <= '0;
			proc_idx_q <= '0;
			best_vld_q <= 1'b0;
			best_idx_q <= '0;
		end else if (ctl.tick_start) begin
			rd_idx_q   <= IDX_W'(1);
			proc_idx_q <= '0;
			best_vld_q <= 1'b0;
		end else if (ctl.scan_en) begin
			rd_idx_q   <= rd_idx_q + IDX_W'(1);
			proc_idx_q <= rd_idx_q;
			if (take) begin
				best_vld_q <= 1'b1;
				best_idx_q <= proc_idx_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.scan_en && take) begin
			best_q <= upd;
		end
	end

	// time and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (ctl.commit) begin
				time_q    <= time_q + rmts_pkg::TIME_W'(1);
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			tick_time_q <= time_q;
			running_q   <= best_vld_q ?
				rmts_pkg::RUNNING_W'({1'b0, best_idx_q} + (IDX_W + 1)'(1)) : '0;
		end
	end

	assign out_valid    = out_vld_q;
	assign tick_time    = tick_time_q;
	assign running_task = running_q;

endmodule

@@ bench/rate_monotonic_tick_scheduler_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench of the rate monotonic tick scheduler: task loads, ticks, stalls, backpressure.
module rate_monotonic_tick_scheduler_top_tb;

	localparam int TASKS         = 8;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int REPORT_MAX    = 10;

	// One pending command item plus the idling it runs under.
	typedef struct {
		logic                          mode;
		logic [rmts_pkg::SLOT_W-1:0]   task_slot;
		logic [rmts_pkg::PERIOD_W-1:0] task_period;
		logic [rmts_pkg::BUDGET_W-1:0] task_budget;
		logic [rmts_pkg::TIME_W-1:0]   first_release;
		int                            idle_pct;
		int                            stall_pct;
		bit                            drain;
		bit                            hold;
	} cmd_item_t;

	// One scheduling decision as it leaves the block.
	typedef struct packed {
		logic [rmts_pkg::TIME_W-1:0]    tick_time;
		logic [rmts_pkg::RUNNING_W-1:0] running_task;
	} decision_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	rmts_cmd_if   cmd ();
	rmts_sched_if sched ();

	rate_monotonic_tick_scheduler_top #(.TASK_COUNT(TASKS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sched(sched)
	);

	// Bench-side copies of every block input, known from time zero.
	logic                          cmd_valid         = 1'b0;
	logic                          cmd_mode          = rmts_pkg::MODE_LOAD;
	logic [rmts_pkg::SLOT_W-1:0]   cmd_task_slot     = '0;
	logic [rmts_pkg::PERIOD_W-1:0] cmd_task_period   = '0;
	logic [rmts_pkg::BUDGET_W-1:0] cmd_task_budget   = '0;
	logic [rmts_pkg::TIME_W-1:0]   cmd_first_release = '0;
	logic                          sched_ready       = 1'b0;

	assign cmd.valid         = cmd_valid;
	assign cmd.mode          = cmd_mode;
	assign cmd.task_slot     = cmd_task_slot;
	assign cmd.task_period   = cmd_task_period;
	assign cmd.task_budget   = cmd_task_budget;
	assign cmd.first_release = cmd_first_release;
	assign sched.ready       = sched_ready;

	// Shadow task table, cleared as after reset (reset is applied only once).
	logic [rmts_pkg::PERIOD_W-1:0] sim_period    [TASKS] = '{default: '0};
	logic [rmts_pkg::BUDGET_W-1:0] sim_budget    [TASKS] = '{default: '0};
	logic [rmts_pkg::TIME_W-1:0]   sim_next_rel  [TASKS] = '{default: '0};
	logic [rmts_pkg::BUDGET_W-1:0] sim_remaining [TASKS] = '{default: '0};
	logic [rmts_pkg::TIME_W-1:0]   sim_time = '0;

	cmd_item_t   pending_cmds[$];
	decision_t   decisions_due[$];
	logic [rmts_pkg::TIME_W-1:0] gen_time = '0;

	int          fail_count    = 0;
	int          stall_pct     = 0;
	int          hold_requests = 0;
	int          holds_taken   = 0;
	int          hold_left     = 0;
	int          cycles        = 0;

	logic        got_valid = 1'b0;
	decision_t   got;

	// Clock; hold reset low at the start, then release it for good.
	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic void note_failure(string msg);
		if (fail_count < REPORT_MAX)
			$display("mismatch at %0t: %s", $realtime, msg);
		fail_count++;
	endfunction

	// Apply one accepted item to the shadow table; a tick queues its decision.
	task automatic advance_schedule(input logic mode, input logic [rmts_pkg::SLOT_W-1:0] slot,
			input logic [rmts_pkg::PERIOD_W-1:0] period,
			input logic [rmts_pkg::BUDGET_W-1:0] budget,
			input logic [rmts_pkg::TIME_W-1:0] first);
		int        pick;
		decision_t d;
		pick = -1;
		if (mode == rmts_pkg::MODE_LOAD) begin
			// Drop loads past the table; a reload also drops the job in flight.
			if (int'(slot) < TASKS) begin
				sim_period[slot]    = period;
				sim_budget[slot]    = budget;
				sim_next_rel[slot]  = first;
				sim_remaining[slot] = '0;
			end
		end else begin
			// Release due tasks first: refill the budget, advance the release time.
			for (int k = 0; k < TASKS; k++) begin
				if (sim_period[k] != '0 && sim_next_rel[k] == sim_time) begin
					sim_remaining[k] = sim_budget[k];
					sim_next_rel[k]  = sim_next_rel[k] + rmts_pkg::TIME_W'(sim_period[k]);
				end
			end
			// Shortest period wins; strict compare keeps the lowest index on a tie.
			for (int k = 0; k < TASKS; k++) begin
				if (sim_remaining[k] != '0) begin
					if (pick < 0 || sim_period[k] < sim_period[pick])
						pick = k;
				end
			end
			d.tick_time    = sim_time;
			d.running_task = '0;
			if (pick >= 0) begin
				sim_remaining[pick] = sim_remaining[pick] - 1'b1;
				d.running_task      = rmts_pkg::RUNNING_W'(pick + 1);
			end
			decisions_due.push_back(d);
			sim_time = sim_time + 1'b1;
		end
	endtask

	// Queue one item; track the time the block will have when it takes the item.
	task automatic push_item(input cmd_item_t it);
		pending_cmds.push_back(it);
		if (it.mode == rmts_pkg::MODE_TICK)
			gen_time = gen_time + 1'b1;
	endtask

	task automatic push_load(input int slot, input int period, input int budget,
			input logic [rmts_pkg::TIME_W-1:0] first);
		cmd_item_t it;
		it = '{rmts_pkg::MODE_LOAD, rmts_pkg::SLOT_W'(slot), rmts_pkg::PERIOD_W'(period),
			rmts_pkg::BUDGET_W'(budget), first, 0, 0, 1'b0, 1'b0};
		push_item(it);
	endtask

	task automatic push_tick(input int count);
		cmd_item_t it;
		it = '{rmts_pkg::MODE_TICK, '0, '0, '0, '0, 0, 0, 1'b0, 1'b0};
		repeat (count) push_item(it);
	endtask

	// Mostly well-formed task sets released soon after load, some raw noise,
	// with ticks dominating so that releases, preemption and drops all happen.
	task automatic push_random(input int idle, input int stall, input bit drain,
			input bit hold);
		cmd_item_t it;
		it.idle_pct  = idle;
		it.stall_pct = stall;
		it.drain     = drain;
		it.hold      = hold;
		it.task_slot     = rmts_pkg::SLOT_W'($urandom_range(TASKS - 1));
		it.task_period   = '0;
		it.task_budget   = '0;
		it.first_release = '0;
		if ($urandom_range(99) < 30) begin
			it.mode = rmts_pkg::MODE_LOAD;
			if ($urandom_range(99) < 85) begin
				it.task_period = rmts_pkg::PERIOD_W'($urandom_range(24, 1));
				if ($urandom_range(99) < 80)
					it.task_budget =
						rmts_pkg::BUDGET_W'($urandom_range(int'(it.task_period), 1));
				else
					it.task_budget = rmts_pkg::BUDGET_W'($urandom_range(40, 1));
				it.first_release = gen_time + rmts_pkg::TIME_W'($urandom_range(30));
			end else begin
				it.task_period   = ($urandom_range(9) == 0) ? '0 :
					rmts_pkg::PERIOD_W'($urandom);
				it.task_budget   = ($urandom_range(9) == 0) ? '0 :
					rmts_pkg::BUDGET_W'($urandom);
				it.first_release = $urandom;
			end
		end else begin
			it.mode = rmts_pkg::MODE_TICK;
			it.task_period   = rmts_pkg::PERIOD_W'($urandom);
			it.task_budget   = rmts_pkg::BUDGET_W'($urandom);
			it.first_release = $urandom;
		end
		push_item(it);
	endtask

	// Build the whole item stream up front.
	initial begin
		// Idle tick before any task exists.
		push_tick(1);
		// Longest period, so lowest priority; never reached release time.
		push_load(7, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		// Disabled task: zero period never releases.
		push_load(0, 0, 5, 2);
		// Zero budget: released but never ready.
		push_load(1, 3, 0, 2);
		// Equal periods released together: lower index goes first.
		push_load(2, 4, 2, 2);
		push_load(3, 4, 2, 2);
		// Period of one preempts everything from its first release on.
		push_load(4, 1, 1, 8);
		// Long job that each release drops and restarts.
		push_load(5, 6, 16'hFFFF, 5);
		push_tick(6);
		// Reload mid-job: remaining work clears.
		push_load(5, 2, 1, gen_time + 1);
		push_load(6, 16'h8000, 16'h8000, gen_time);
		push_tick(6);

		// No idling; then a long result hold-off that backs the block up.
		push_random(0, 0, 1'b0, 1'b1);
		repeat (40) push_random(0, 0, 1'b0, 1'b0);
		repeat (110) push_random(0, 0, 1'b0, 1'b0);
		// Sender mostly idle; start only once every decision is in.
		push_random(82, 0, 1'b1, 1'b0);
		repeat (149) push_random(82, 0, 1'b0, 1'b0);
		// Receiver mostly stalling.
		push_random(0, 82, 1'b1, 1'b0);
		repeat (149) push_random(0, 82, 1'b0, 1'b0);
		// Both sides idling; close with a second hold-off.
		push_random(30, 30, 1'b1, 1'b0);
		repeat (109) push_random(30, 30, 1'b0, 1'b0);
		push_random(0, 0, 1'b0, 1'b1);
		repeat (39) push_random(0, 0, 1'b0, 1'b0);
	end

	// Command driver: predict on each accepted item, hold an unaccepted one,
	// otherwise offer the next pending item unless idling or draining.
	always @(posedge clk or negedge arst_n) begin
		cmd_item_t nxt;
		logic      took;
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else begin
			took = cmd_valid && (cmd.ready === 1'b1);
			if (took)
				advance_schedule(cmd_mode, cmd_task_slot, cmd_task_period, cmd_task_budget,
					cmd_first_release);
			if (cmd_valid && !took) begin
				// Hold the offered item until the block takes it.
			end else if (pending_cmds.size() != 0
					&& !(pending_cmds[0].drain && decisions_due.size() != 0)
					&& $urandom_range(99) >= pending_cmds[0].idle_pct) begin
				nxt = pending_cmds.pop_front();
				cmd_valid         <= 1'b1;
				cmd_mode          <= nxt.mode;
				cmd_task_slot     <= nxt.task_slot;
				cmd_task_period   <= nxt.task_period;
				cmd_task_budget   <= nxt.task_budget;
				cmd_first_release <= nxt.first_release;
				stall_pct         <= nxt.stall_pct;
				if (nxt.hold)
					hold_requests <= hold_requests + 1;
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// Result ready: a requested hold-off is counted out here, else random stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sched_ready <= 1'b0;
		end else if (holds_taken != hold_requests) begin
			holds_taken <= hold_requests;
			hold_left   <= HOLD_CYCLES;
			sched_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left   <= hold_left - 1;
			sched_ready <= 1'b0;
		end else begin
			sched_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Capture each accepted decision at the edge.
	always @(posedge clk) begin
		got_valid <= arst_n && (sched.valid === 1'b1) && sched_ready;
		got       <= {sched.tick_time, sched.running_task};
	end

	// Compare at the falling edge, clear of the edge where predictions land.
	always @(negedge clk) begin
		decision_t want;
		if (got_valid) begin
			if (decisions_due.size() == 0) begin
				note_failure($sformatf("unexpected decision time %0d task %0d",
					got.tick_time, got.running_task));
			end else begin
				want = decisions_due.pop_front();
				if (got.tick_time !== want.tick_time)
					note_failure($sformatf("tick_time exp %0d got %0d",
						want.tick_time, got.tick_time));
				if (got.running_task !== want.running_task)
					note_failure($sformatf("running_task at time %0d exp %0d got %0d",
						want.tick_time, want.running_task, got.running_task));
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Wait for the stream to drain and every decision to arrive, then settle.
	initial begin
		do @(negedge clk);
		while (!arst_n || pending_cmds.size() != 0 || cmd_valid || decisions_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (decisions_due.size() != 0)
			note_failure($sformatf("%0d decisions never arrived", decisions_due.size()));
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ rate_monotonic_tick_scheduler_top.f @@
design/rmts_pkg.sv
design/rmts_cmd_if.sv
design/rmts_sched_if.sv
design/rmts_ctrl.sv
design/rmts_dp.sv
design/rate_monotonic_tick_scheduler_top.sv
bench/rate_monotonic_tick_scheduler_top_tb.sv
